FILE: sv/sliding_palindrome_detector_assert.svh
// assertion macros for the sliding palindrome detector
// each use stands on a line of its own at the end of a module
`ifndef SLIDING_PALINDROME_DETECTOR_ASSERT_SVH
`define SLIDING_PALINDROME_DETECTOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spd assertion failed");

// next-cycle implication, checked outside reset
`define SPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spd assertion failed");

`endif

FILE: sv/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants and types for the sliding palindrome detector.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

   // window store depth and position counter width
   localparam int MAX_WINDOW    = 32;
   localparam int POSITION_BITS = 48;

   // field widths
   localparam int SYM_BITS = 8;
   localparam int LEN_BITS = 6;
   localparam int IDX_BITS = $clog2(MAX_WINDOW);

   // window length after reset
   localparam logic [LEN_BITS-1:0] RESET_LEN = 6'd21;

   // broadcast from the input side to every cell
   typedef struct packed {
      logic                shift;
      logic [SYM_BITS-1:0] symbol;
      logic                nonzero;
   } cell_bcast_type;

   // load request into the result register
   typedef struct packed {
      logic load;
      logic hit;
   } out_load_type;

endpackage

`default_nettype wire

FILE: sv/spd_cell.sv
// ----------------------------------------------------------------------------
// spd_cell
// One cell of the window chain: holds one stored byte and the flag that the
// window ending at the newest symbol, reaching back to this cell, mirrors.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  wire spd_pkg::cell_bcast_type bcast,
   input  wire [spd_pkg::SYM_BITS-1:0] byte_prev,
   input  wire                         inner_match,
   output logic [spd_pkg::SYM_BITS-1:0] byte_q,
   output logic                        match_q,
   output logic                        match_next
);

   logic [spd_pkg::SYM_BITS-1:0] byte_ff;
   logic                         match_ff;
   logic                         match_in;

   // outer pair compares the new symbol with the byte about to move in,
   // the inner window comes from two cells down
   always_comb begin
      match_in = bcast.nonzero && (bcast.symbol == byte_prev) && inner_match;
   end

   // shift on every accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff  <= '0;
         match_ff <= 1'b0;
      end else if (bcast.shift) begin
         byte_ff  <= byte_prev;
         match_ff <= match_in;
      end
   end

   assign byte_q     = byte_ff;
   assign match_q    = match_ff;
   assign match_next = match_in;

endmodule

`default_nettype wire

FILE: sv/spd_out_stage.sv
// ----------------------------------------------------------------------------
// spd_out_stage
// Result register: holds one start position until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_out_stage (
   input  wire                              clock,
   input  wire                              reset,
   input  wire spd_pkg::out_load_type       ctrl,
   input  wire [spd_pkg::POSITION_BITS-1:0] load_data,
   input  wire                              rsp_tready,
   output logic                             rsp_tvalid,
   output logic [spd_pkg::POSITION_BITS-1:0] rsp_tdata,
   output logic                             space
);

   logic                              valid_ff;
   logic                              valid_in;
   logic [spd_pkg::POSITION_BITS-1:0] data_ff;

   // free when empty or being drained this cycle
   assign space = !valid_ff || rsp_tready;

   // next valid state
   always_comb begin
      if (ctrl.load) begin
         valid_in = ctrl.hit;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (ctrl.load && ctrl.hit) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

FILE: sv/sliding_palindrome_detector.sv
// ----------------------------------------------------------------------------
// sliding_palindrome_detector
// Scans a byte stream and reports the start position of every window of the
// configured length that reads the same both ways and holds no zero byte.
// ----------------------------------------------------------------------------
//   channel   direction  tdata / data                 handshake
//   req       in         [7:0] symbol                 req_tvalid/req_tready
//   rsp       out        [47:0] start_position        rsp_tvalid/rsp_tready
//   csr       in         [5:0] window_length          csr_wr_en, no wait
//
// One symbol per cycle unless stalled; its result shows in the cycle after.
// Each cell updates its mirror flag from the cell two places down, so the
// chain needs a single compare per cell and no wide loop.
// Reset clears the chain, the position counter and the result register.
// req_tready drops only while a result is held and rsp_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_palindrome_detector (
   input  wire                              clock,
   input  wire                              reset,
   // fields from bit 0: symbol[7:0]
   input  wire [7:0]                        req_tdata,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // fields from bit 0: start_position[47:0]
   output logic [47:0]                      rsp_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire                              csr_wr_en,
   input  wire [spd_pkg::LEN_BITS-1:0]      csr_wr_data
);

   logic [spd_pkg::LEN_BITS-1:0]      len_ff;
   logic [spd_pkg::POSITION_BITS-1:0] seen_ff;
   logic [spd_pkg::POSITION_BITS-1:0] seen_in;
   logic [spd_pkg::LEN_BITS-1:0]      len_eff;
   logic [spd_pkg::IDX_BITS-1:0]      sel_idx;
   logic [spd_pkg::POSITION_BITS-1:0] position;
   logic                              hit;
   logic                              accept;
   logic                              space;

   spd_pkg::cell_bcast_type           bcast;
   spd_pkg::out_load_type             out_ctrl;

   logic [spd_pkg::SYM_BITS-1:0]      cell_byte  [spd_pkg::MAX_WINDOW];
   logic                              cell_match [spd_pkg::MAX_WINDOW];
   logic [spd_pkg::MAX_WINDOW-1:0]    match_next;

   // window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= spd_pkg::RESET_LEN;
      end else if (csr_wr_en) begin
         len_ff <= csr_wr_data;
      end
   end

   // input handshake
   assign req_tready = space;
   assign accept     = req_tvalid && space;

   // broadcast to the chain
   always_comb begin
      bcast.shift   = accept;
      bcast.symbol  = req_tdata;
      bcast.nonzero = (req_tdata != '0);
   end

   // chain of cells, cell k covers the window of length k+1
   for (genvar k = 0; k < spd_pkg::MAX_WINDOW; k++) begin : g_cell
      logic [spd_pkg::SYM_BITS-1:0] prev_byte;
      logic                         inner;

      if (k == 0) begin : g_first
         assign prev_byte = req_tdata;
      end else begin : g_rest
         assign prev_byte = cell_byte[k-1];
      end

      if (k < 2) begin : g_short
         assign inner = 1'b1;
      end else begin : g_long
         assign inner = cell_match[k-2];
      end

      spd_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .bcast       (bcast),
         .byte_prev   (prev_byte),
         .inner_match (inner),
         .byte_q      (cell_byte[k]),
         .match_q     (cell_match[k]),
         .match_next  (match_next[k])
      );
   end

   // clamp the length and pick the matching cell
   always_comb begin
      if (len_ff > spd_pkg::LEN_BITS'(spd_pkg::MAX_WINDOW)) begin
         len_eff = spd_pkg::LEN_BITS'(spd_pkg::MAX_WINDOW);
      end else begin
         len_eff = len_ff;
      end
      sel_idx  = spd_pkg::IDX_BITS'(len_eff - spd_pkg::LEN_BITS'(1));
      hit      = (len_eff != '0) && match_next[sel_idx];
      seen_in  = seen_ff + spd_pkg::POSITION_BITS'(1);
      position = seen_in - spd_pkg::POSITION_BITS'(len_eff);
   end

   // symbol counter, wraps at its width
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (accept) begin
         seen_ff <= seen_in;
      end
   end

   // result register
   always_comb begin
      out_ctrl.load = accept;
      out_ctrl.hit  = hit;
   end

   spd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (out_ctrl),
      .load_data  (position),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .space      (space)
   );

   // checks
`include "sliding_palindrome_detector_assert.svh"

   `SPD_ASSERT_NOW(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `SPD_ASSERT_NEXT(a_count_steps, clock, reset, accept, seen_ff == $past(seen_in))
   `SPD_ASSERT_NEXT(a_zero_no_result, clock, reset, accept && (req_tdata == '0), !rsp_tvalid)
   `SPD_ASSERT_NOW(a_first_cell_flag, clock, reset, 1'b1, cell_match[0] == (cell_byte[0] != '0))

endmodule

`default_nettype wire
